// ===== sv/lphs_pkg.sv =====
// Shared constants and types for the linear-probing hash set.
// No dependencies; imported by the linear_probe_hash_set top level.
package lphs_pkg;

  // Table geometry. CAPACITY must be a power of two: the home slot is the
  // low address bits of the key.
  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 32;

  // Fixed widths of the port fields.
  localparam int CMD_W    = 2;
  localparam int KEY_IN_W = 32;
  localparam int LIVE_W   = 7;

  // Derived widths and limits.
  localparam int KEY_W      = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int LOAD_DIV   = 4;
  localparam int LOAD_LIMIT = CAPACITY - CAPACITY / LOAD_DIV;
  localparam int MARK_W     = 2;
  localparam int SLOT_W     = MARK_W + KEY_W;

  // Command codes; any other code is treated as a query.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // Slot marks as stored in the slot RAM.
  localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
  localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

endpackage

// ===== sv/lphs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; contents are undefined until written.
module lphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/linear_probe_hash_set.sv =====
// Fixed-capacity hash set of keys, open addressing with linear probing.
// Depends on lphs_pkg and lphs_ram.
//
// Each start transaction carries a command (insert, delete, query) and a key.
// The probe begins at slot (key mod CAPACITY) and walks forward with
// wraparound, one slot RAM read per cycle, until it meets an empty slot, the
// matching key, or has visited every slot; tombstones are stepped over. A
// transaction probes from 1 to CAPACITY slots through the single read port
// of the slot RAM. busy stays high from acceptance until the result cycle.
// The result appears on the out_ ports for exactly one cycle with out_valid
// high; the receiver cannot stall it, so capture it in that cycle. Slot marks
// come out of reset as empty through per-slot valid flops, so no clearing pass
// runs and the block accepts a transaction in the first cycle after reset.
// An insert of a new key is refused (out_status high) once the set holds
// three quarters of CAPACITY keys.
module linear_probe_hash_set (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [lphs_pkg::CMD_W-1:0]    in_cmd,
  input  logic [lphs_pkg::KEY_IN_W-1:0] in_key,
  output logic                          out_valid,
  output logic                          out_was_present,
  output logic                          out_status,
  output logic [lphs_pkg::LIVE_W-1:0]   out_live_count
);
  import lphs_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_PROBE
  } state_t;

  // Control and request registers.
  state_t            state_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [IDX_W-1:0]  pos_r;       // slot whose RAM data arrives this cycle
  logic [IDX_W-1:0]  step_r;      // slots probed before pos_r
  logic              free_vld_r;  // a free slot was met earlier in the probe
  logic [IDX_W-1:0]  free_r;
  logic [CNT_W-1:0]  count_r;
  logic [CAPACITY-1:0] vld_r;     // slot has been written since reset

  // Registered result outputs.
  logic              out_valid_r;
  logic              out_was_present_r;
  logic              out_status_r;
  logic [LIVE_W-1:0] out_live_count_r;

  // Slot RAM interface.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;

  // Probe decode.
  logic [MARK_W-1:0] mark;
  logic              is_empty;
  logic              is_del;
  logic              is_hit;
  logic              last_step;
  logic              stop;
  logic [IDX_W-1:0]  pos_inc;
  logic              free_vld_nxt;
  logic [IDX_W-1:0]  free_nxt;
  logic              room;
  logic              status_nxt;
  logic [CNT_W-1:0]  count_nxt;

  lphs_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (CAPACITY)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_was_present = out_was_present_r;
  assign out_status      = out_status_r;
  assign out_live_count  = out_live_count_r;

  always_comb begin
    // A slot never written since reset reads as empty.
    mark      = vld_r[pos_r] ? ram_rdata[KEY_W +: MARK_W] : MARK_EMPTY;
    is_empty  = (mark == MARK_EMPTY);
    is_del    = (mark == MARK_DELETED);
    is_hit    = (mark == MARK_USED) && (ram_rdata[KEY_W-1:0] == key_r);
    last_step = (step_r == IDX_W'(CAPACITY - 1));
    stop      = is_empty || is_hit || last_step;
    pos_inc   = (pos_r == IDX_W'(CAPACITY - 1)) ? '0 : pos_r + 1'b1;

    // Remember the first empty or tombstone slot met.
    free_vld_nxt = free_vld_r || is_empty || is_del;
    free_nxt     = free_vld_r ? free_r : pos_r;

    room = (count_r < CNT_W'(LOAD_LIMIT)) && free_vld_nxt;

    // Issue the first read on acceptance, then one read per probe step.
    ram_raddr = (state_r == S_IDLE) ? in_key[IDX_W-1:0] : pos_inc;

    ram_we     = 1'b0;
    ram_waddr  = free_nxt;
    ram_wdata  = {MARK_USED, key_r};
    status_nxt = 1'b0;
    count_nxt  = count_r;

    if (state_r == S_PROBE && stop) begin
      case (cmd_r)
        CMD_INSERT: begin
          if (!is_hit) begin
            if (room) begin
              ram_we    = 1'b1;
              count_nxt = count_r + 1'b1;
            end else begin
              status_nxt = 1'b1;
            end
          end
        end
        CMD_DELETE: begin
          if (is_hit) begin
            ram_we    = 1'b1;
            ram_waddr = pos_r;
            ram_wdata = {MARK_DELETED, {KEY_W{1'b0}}};
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          // Query, or an unused code: leave the table alone.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      vld_r       <= '0;
      free_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            // Latch the transaction; its first slot read is already issued.
            cmd_r      <= in_cmd;
            key_r      <= in_key[KEY_W-1:0];
            pos_r      <= in_key[IDX_W-1:0];
            step_r     <= '0;
            free_vld_r <= 1'b0;
            state_r    <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (stop) begin
            // Drop the probe, commit the count and present the result.
            count_r           <= count_nxt;
            out_valid_r       <= 1'b1;
            out_was_present_r <= is_hit;
            out_status_r      <= status_nxt;
            out_live_count_r  <= LIVE_W'(count_nxt);
            state_r           <= S_IDLE;
          end else begin
            // Advance to the next slot, whose read was issued this cycle.
            pos_r      <= pos_inc;
            step_r     <= step_r + 1'b1;
            free_vld_r <= free_vld_nxt;
            free_r     <= free_nxt;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
